// ----- rtl/core/movdec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movdec_pkg
// Shared types and codes for the MOV byte decoder: opcode tags, ModRM codes,
// operand kinds and the queue entry passed from the front to the back.
// ----------------------------------------------------------------------------
package movdec_pkg;

    // Opcode tags, upper six bits of the first byte
    localparam logic [5:0] REGMEM_TAG = 6'b100010;
    localparam logic [5:0] ACCUM_TAG  = 6'b101000;

    // ModRM codes
    localparam logic [2:0] DIRECT_RM = 3'b110;
    localparam logic [1:0] MOD_NODISP = 2'b00;
    localparam logic [1:0] MOD_DISP8  = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [1:0] MOD_REG    = 2'b11;

    // Byte counter codes
    localparam logic [2:0] DUE_OPCODE = 3'd0;
    localparam logic [2:0] DUE_ONE    = 3'd1;
    localparam logic [2:0] DUE_TWO    = 3'd2;
    localparam logic [2:0] DUE_MODRM  = 3'd4;

    // Operand kinds on rm_kind
    localparam logic [2:0] KIND_REG    = 3'd0;
    localparam logic [2:0] KIND_DIRECT = 3'd1;
    localparam logic [2:0] KIND_BASED  = 3'd2;
    localparam logic [2:0] KIND_DISP8  = 3'd3;
    localparam logic [2:0] KIND_DISP16 = 3'd4;

    // Entry classes
    localparam logic [1:0] ENT_INVALID = 2'd0;
    localparam logic [1:0] ENT_REGMEM  = 2'd1;
    localparam logic [1:0] ENT_ACCUM   = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] opcode;
        logic [7:0] modrm;
        logic [7:0] disp_lo;
        logic [7:0] disp_hi;
    } entry_t;

endpackage

// ----- rtl/core/mov_instruction_byte_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mov_instruction_byte_decoder
// Byte-serial decoder for the 8086 MOV r/m<->reg and memory<->accumulator
// forms, one code byte per beat in, one decoded instruction per beat out.
// ----------------------------------------------------------------------------
// One code byte is taken every cycle while the two-entry queue has room; a
// byte is never held up by the decode itself. A result beat is presented once
// its entry, written into the queue at the edge that takes the last byte of
// its instruction, has moved into the output register, which it does when
// that register is empty or being emptied. Results leave at up to one per
// cycle, set by the output register and queue pop. An opcode byte that is neither
// 100010dw nor 101000dw gives a beat with inst_valid low and every other
// field zero. The accumulator forms always consume a 16-bit direct address,
// low byte first. An 8-bit displacement is reported zero extended.
// ----------------------------------------------------------------------------
module mov_instruction_byte_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_code_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_inst_valid,
    output logic        m_rm_first,
    output logic [3:0]  m_reg_code,
    output logic [2:0]  m_rm_kind,
    output logic [3:0]  m_rm_code,
    output logic [15:0] m_displacement
);

    logic               byte_accept;
    logic               push;
    movdec_pkg::entry_t push_entry;
    logic               has_space;
    logic               head_valid;
    movdec_pkg::entry_t head_entry;
    logic               pop;

    // Room in the queue covers the worst case of a result on this beat.
    assign s_ready     = has_space;
    assign byte_accept = s_valid && s_ready;

    movdec_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_accept(byte_accept),
        .code_byte  (s_code_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    movdec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .has_space  (has_space),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    movdec_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_entry     (head_entry),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inst_valid   (m_inst_valid),
        .m_rm_first     (m_rm_first),
        .m_reg_code     (m_reg_code),
        .m_rm_kind      (m_rm_kind),
        .m_rm_code      (m_rm_code),
        .m_displacement (m_displacement)
    );

endmodule

// ----- rtl/core/movdec_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movdec_front
// Byte collector: tracks bytes still due, holds opcode, ModRM and the low
// displacement byte, and pushes one classified entry per finished instruction.
// ----------------------------------------------------------------------------
module movdec_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           code_byte,
    output logic                 push,
    output movdec_pkg::entry_t   push_entry
);

    logic [2:0] bytes_due_reg, bytes_due_next;
    logic [7:0] opcode_reg, opcode_next;
    logic [7:0] modrm_reg, modrm_next;
    logic [7:0] low_reg, low_next;

    always_comb begin
        bytes_due_next = bytes_due_reg;
        opcode_next    = opcode_reg;
        modrm_next     = modrm_reg;
        low_next       = low_reg;
        push           = 1'b0;
        push_entry     = '0;
        if (byte_accept) begin
            case (bytes_due_reg)
                movdec_pkg::DUE_MODRM: begin
                    modrm_next = code_byte;
                    case (code_byte[7:6])
                        movdec_pkg::MOD_NODISP: bytes_due_next =
                            (code_byte[2:0] == movdec_pkg::DIRECT_RM) ?
                            movdec_pkg::DUE_TWO : movdec_pkg::DUE_OPCODE;
                        movdec_pkg::MOD_DISP8:  bytes_due_next = movdec_pkg::DUE_ONE;
                        movdec_pkg::MOD_DISP16: bytes_due_next = movdec_pkg::DUE_TWO;
                        default:                bytes_due_next = movdec_pkg::DUE_OPCODE;
                    endcase
                    if (bytes_due_next == movdec_pkg::DUE_OPCODE) begin
                        push             = 1'b1;
                        push_entry.cls   = movdec_pkg::ENT_REGMEM;
                        push_entry.opcode = opcode_reg;
                        push_entry.modrm = code_byte;
                    end
                end
                movdec_pkg::DUE_TWO: begin
                    low_next       = code_byte;
                    bytes_due_next = movdec_pkg::DUE_ONE;
                end
                movdec_pkg::DUE_ONE: begin
                    bytes_due_next    = movdec_pkg::DUE_OPCODE;
                    push              = 1'b1;
                    push_entry.opcode = opcode_reg;
                    push_entry.modrm  = modrm_reg;
                    if (opcode_reg[7:2] == movdec_pkg::ACCUM_TAG) begin
                        push_entry.cls     = movdec_pkg::ENT_ACCUM;
                        push_entry.disp_lo = low_reg;
                        push_entry.disp_hi = code_byte;
                    end else if (modrm_reg[7:6] == movdec_pkg::MOD_DISP8) begin
                        push_entry.cls     = movdec_pkg::ENT_REGMEM;
                        push_entry.disp_lo = code_byte;
                    end else begin
                        push_entry.cls     = movdec_pkg::ENT_REGMEM;
                        push_entry.disp_lo = low_reg;
                        push_entry.disp_hi = code_byte;
                    end
                end
                default: begin
                    // awaiting an opcode, unused counts land here too
                    bytes_due_next = movdec_pkg::DUE_OPCODE;
                    if (code_byte[7:2] == movdec_pkg::REGMEM_TAG) begin
                        opcode_next    = code_byte;
                        bytes_due_next = movdec_pkg::DUE_MODRM;
                    end else if (code_byte[7:2] == movdec_pkg::ACCUM_TAG) begin
                        opcode_next    = code_byte;
                        bytes_due_next = movdec_pkg::DUE_TWO;
                    end else begin
                        push           = 1'b1;
                        push_entry.cls = movdec_pkg::ENT_INVALID;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_due_reg <= movdec_pkg::DUE_OPCODE;
            opcode_reg    <= '0;
            modrm_reg     <= '0;
            low_reg       <= '0;
        end else begin
            bytes_due_reg <= bytes_due_next;
            opcode_reg    <= opcode_next;
            modrm_reg     <= modrm_next;
            low_reg       <= low_next;
        end
    end

endmodule

// ----- rtl/core/movdec_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movdec_queue
// Short register queue between byte collector and result formatter.
// ----------------------------------------------------------------------------
module movdec_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  movdec_pkg::entry_t   push_entry,
    output logic                 has_space,
    output logic                 head_valid,
    output movdec_pkg::entry_t   head_entry,
    input  logic                 pop
);

    movdec_pkg::entry_t slot_reg [movdec_pkg::QUEUE_DEPTH];
    logic [movdec_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [movdec_pkg::QCNT_W-1:0] count_reg;

    assign has_space  = (count_reg != movdec_pkg::QCNT_W'(movdec_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == movdec_pkg::QPTR_W'(movdec_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == movdec_pkg::QPTR_W'(movdec_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/movdec_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movdec_back
// Result formatter: turns a queued entry into operand fields and holds them
// in the output register until the beat is taken.
// ----------------------------------------------------------------------------
module movdec_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  movdec_pkg::entry_t   head_entry,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_inst_valid,
    output logic                 m_rm_first,
    output logic [3:0]           m_reg_code,
    output logic [2:0]           m_rm_kind,
    output logic [3:0]           m_rm_code,
    output logic [15:0]          m_displacement
);

    logic        valid_reg;
    logic        inst_valid_next, rm_first_next;
    logic [3:0]  reg_code_next, rm_code_next;
    logic [2:0]  rm_kind_next;
    logic [15:0] disp_next;
    logic        inst_valid_reg, rm_first_reg;
    logic [3:0]  reg_code_reg, rm_code_reg;
    logic [2:0]  rm_kind_reg;
    logic [15:0] disp_reg;

    logic       w_bit, d_bit;
    logic [1:0] mod_f;
    logic [2:0] rm_f;

    assign w_bit = head_entry.opcode[0];
    assign d_bit = head_entry.opcode[1];
    assign mod_f = head_entry.modrm[7:6];
    assign rm_f  = head_entry.modrm[2:0];

    always_comb begin
        inst_valid_next = 1'b0;
        rm_first_next   = 1'b0;
        reg_code_next   = '0;
        rm_kind_next    = movdec_pkg::KIND_REG;
        rm_code_next    = '0;
        disp_next       = '0;
        case (head_entry.cls)
            movdec_pkg::ENT_ACCUM: begin
                inst_valid_next = 1'b1;
                rm_first_next   = d_bit;
                reg_code_next   = {w_bit, 3'b000};
                rm_kind_next    = movdec_pkg::KIND_DIRECT;
                rm_code_next    = {1'b0, movdec_pkg::DIRECT_RM};
                disp_next       = {head_entry.disp_hi, head_entry.disp_lo};
            end
            movdec_pkg::ENT_REGMEM: begin
                inst_valid_next = 1'b1;
                rm_first_next   = ~d_bit;
                reg_code_next   = {w_bit, head_entry.modrm[5:3]};
                rm_code_next    = {1'b0, rm_f};
                case (mod_f)
                    movdec_pkg::MOD_REG: begin
                        rm_kind_next = movdec_pkg::KIND_REG;
                        rm_code_next = {w_bit, rm_f};
                    end
                    movdec_pkg::MOD_NODISP: begin
                        if (rm_f == movdec_pkg::DIRECT_RM) begin
                            rm_kind_next = movdec_pkg::KIND_DIRECT;
                            disp_next    = {head_entry.disp_hi, head_entry.disp_lo};
                        end else begin
                            rm_kind_next = movdec_pkg::KIND_BASED;
                        end
                    end
                    movdec_pkg::MOD_DISP8: begin
                        rm_kind_next = movdec_pkg::KIND_DISP8;
                        disp_next    = {8'h00, head_entry.disp_lo};
                    end
                    default: begin
                        rm_kind_next = movdec_pkg::KIND_DISP16;
                        disp_next    = {head_entry.disp_hi, head_entry.disp_lo};
                    end
                endcase
            end
            default: begin
                // unmatched opcode: all fields stay zero
            end
        endcase
    end

    assign pop = head_valid && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            inst_valid_reg <= inst_valid_next;
            rm_first_reg   <= rm_first_next;
            reg_code_reg   <= reg_code_next;
            rm_kind_reg    <= rm_kind_next;
            rm_code_reg    <= rm_code_next;
            disp_reg       <= disp_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_inst_valid   = inst_valid_reg;
    assign m_rm_first     = rm_first_reg;
    assign m_reg_code     = reg_code_reg;
    assign m_rm_kind      = rm_kind_reg;
    assign m_rm_code      = rm_code_reg;
    assign m_displacement = disp_reg;

endmodule

// ----- rtl/core/movdec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movdec_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module movdec_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_inst_valid,
    input logic        m_rm_first,
    input logic [3:0]  m_reg_code,
    input logic [2:0]  m_rm_kind,
    input logic [3:0]  m_rm_code,
    input logic [15:0] m_displacement
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inst_valid) && $stable(m_rm_first)
            && $stable(m_reg_code) && $stable(m_rm_kind) && $stable(m_rm_code)
            && $stable(m_displacement))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inst_valid |-> !m_rm_first && m_reg_code == 4'd0
            && m_rm_kind == movdec_pkg::KIND_REG && m_rm_code == 4'd0
            && m_displacement == 16'd0)
        else $error("skipped opcode beat carries nonzero fields");

    a_no_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rm_kind == movdec_pkg::KIND_REG || m_rm_kind == movdec_pkg::KIND_BASED)
            |-> m_displacement == 16'd0)
        else $error("displacement present for a form without one");

    a_disp8: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rm_kind == movdec_pkg::KIND_DISP8 |-> m_displacement[15:8] == 8'd0)
        else $error("8-bit displacement has a nonzero high byte");

endmodule

bind mov_instruction_byte_decoder movdec_checker u_movdec_checker (.*);

// ----- test/mov_decode_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mov_decode_checker
// Watches both channels of the MOV byte decoder, keeps its own model of the
// decode state, and compares every output beat with the oldest expected decode.
// ----------------------------------------------------------------------------
module mov_decode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_code_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_inst_valid,
    input  logic        m_rm_first,
    input  logic [3:0]  m_reg_code,
    input  logic [2:0]  m_rm_kind,
    input  logic [3:0]  m_rm_code,
    input  logic [15:0] m_displacement,
    output int          pending,
    output int          error_count,
    output int          mov_count,
    output int          skip_count
);

    typedef struct packed {
        logic        inst_valid;
        logic        rm_first;
        logic [3:0]  reg_code;
        logic [2:0]  rm_kind;
        logic [3:0]  rm_code;
        logic [15:0] displacement;
    } decode_t;

    // Model of the decode state
    logic [2:0] due_q;
    logic [7:0] opcode_q;
    logic [7:0] modrm_q;
    logic [7:0] low_q;

    decode_t expected_decodes[$];
    decode_t want;

    initial begin
        error_count = 0;
        mov_count   = 0;
        skip_count  = 0;
        pending     = 0;
    end

    // Register/memory form from the held opcode and ModRM
    function automatic decode_t regmem_decode(input logic [15:0] disp);
        decode_t r;
        logic    w;
        w              = opcode_q[0];
        r.inst_valid   = 1'b1;
        r.rm_first     = ~opcode_q[1];
        r.reg_code     = {w, modrm_q[5:3]};
        r.rm_code      = {1'b0, modrm_q[2:0]};
        r.displacement = disp;
        case (modrm_q[7:6])
            movdec_pkg::MOD_REG: begin
                r.rm_kind      = movdec_pkg::KIND_REG;
                r.rm_code      = {w, modrm_q[2:0]};
                r.displacement = 16'h0000;
            end
            movdec_pkg::MOD_NODISP: begin
                if (modrm_q[2:0] == movdec_pkg::DIRECT_RM) begin
                    r.rm_kind = movdec_pkg::KIND_DIRECT;
                end else begin
                    r.rm_kind      = movdec_pkg::KIND_BASED;
                    r.displacement = 16'h0000;
                end
            end
            movdec_pkg::MOD_DISP8: begin
                r.rm_kind      = movdec_pkg::KIND_DISP8;
                r.displacement = {8'h00, disp[7:0]};
            end
            default: r.rm_kind = movdec_pkg::KIND_DISP16;
        endcase
        return r;
    endfunction

    task automatic decode_code_byte(input logic [7:0] b);
        decode_t r;
        logic    emit;
        r    = '0;
        emit = 1'b0;
        case (due_q)
            movdec_pkg::DUE_MODRM: begin
                modrm_q = b;
                if (b[7:6] == movdec_pkg::MOD_REG ||
                    (b[7:6] == movdec_pkg::MOD_NODISP && b[2:0] != movdec_pkg::DIRECT_RM))
                begin
                    due_q = movdec_pkg::DUE_OPCODE;
                    r     = regmem_decode(16'h0000);
                    emit  = 1'b1;
                end else if (b[7:6] == movdec_pkg::MOD_DISP8) begin
                    due_q = movdec_pkg::DUE_ONE;
                end else begin
                    due_q = movdec_pkg::DUE_TWO;
                end
            end
            movdec_pkg::DUE_TWO: begin
                low_q = b;
                due_q = movdec_pkg::DUE_ONE;
            end
            movdec_pkg::DUE_ONE: begin
                due_q = movdec_pkg::DUE_OPCODE;
                emit  = 1'b1;
                if (opcode_q[7:2] == movdec_pkg::ACCUM_TAG) begin
                    r.inst_valid   = 1'b1;
                    r.rm_first     = opcode_q[1];
                    r.reg_code     = {opcode_q[0], 3'b000};
                    r.rm_kind      = movdec_pkg::KIND_DIRECT;
                    r.rm_code      = {1'b0, movdec_pkg::DIRECT_RM};
                    r.displacement = {b, low_q};
                end else if (modrm_q[7:6] == movdec_pkg::MOD_DISP8) begin
                    r = regmem_decode({8'h00, b});
                end else begin
                    r = regmem_decode({b, low_q});
                end
            end
            default: begin
                due_q = movdec_pkg::DUE_OPCODE;
                if (b[7:2] == movdec_pkg::REGMEM_TAG) begin
                    opcode_q = b;
                    due_q    = movdec_pkg::DUE_MODRM;
                end else if (b[7:2] == movdec_pkg::ACCUM_TAG) begin
                    opcode_q = b;
                    due_q    = movdec_pkg::DUE_TWO;
                end else begin
                    emit = 1'b1;    // skipped opcode, all fields zero
                end
            end
        endcase
        if (emit)
            expected_decodes.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            error_count++;
        end
    endtask

    // Output side is checked before the input side: a byte taken at this edge
    // cannot have produced a beat at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            due_q    = movdec_pkg::DUE_OPCODE;
            opcode_q = 8'h00;
            modrm_q  = 8'h00;
            low_q    = 8'h00;
            expected_decodes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_decodes.size() == 0) begin
                    $error("output beat with no decode expected");
                    error_count++;
                end else begin
                    want = expected_decodes.pop_front();
                    check_field("inst_valid", 16'(want.inst_valid), 16'(m_inst_valid));
                    check_field("rm_first", 16'(want.rm_first), 16'(m_rm_first));
                    check_field("reg_code", 16'(want.reg_code), 16'(m_reg_code));
                    check_field("rm_kind", 16'(want.rm_kind), 16'(m_rm_kind));
                    check_field("rm_code", 16'(want.rm_code), 16'(m_rm_code));
                    check_field("displacement", want.displacement, m_displacement);
                    if (want.inst_valid)
                        mov_count++;
                    else
                        skip_count++;
                end
            end
            if (s_valid && s_ready)
                decode_code_byte(s_code_byte);
        end
        pending = expected_decodes.size();
    end

endmodule

// ----- test/tb_mov_instruction_byte_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mov_instruction_byte_decoder
// Drives code bytes into the MOV decoder: a directed set of edge cases, then
// randomized instruction streams mixed with junk bytes, under bursty input
// and a stalling receiver. Checking lives in mov_decode_checker.
// ----------------------------------------------------------------------------
module tb_mov_instruction_byte_decoder;

    localparam int CYCLE_LIMIT  = 200000;   // far beyond the slowest legal run
    localparam int RANDOM_BYTES = 950;
    localparam int HOLD_CYCLES  = 80;       // long receiver hold-off

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_code_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_inst_valid;
    logic        m_rm_first;
    logic [3:0]  m_reg_code;
    logic [2:0]  m_rm_kind;
    logic [3:0]  m_rm_code;
    logic [15:0] m_displacement;

    int pending;
    int error_count;
    int mov_count;
    int skip_count;

    int cycle_count = 0;
    int bytes_sent  = 0;
    int burst_left  = 0;

    // Receiver hold-off handshake: the stimulus flips hold_toggle, the
    // receiver process notices the change and counts the hold itself.
    logic hold_toggle = 1'b0;

    mov_instruction_byte_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inst_valid   (m_inst_valid),
        .m_rm_first     (m_rm_first),
        .m_reg_code     (m_reg_code),
        .m_rm_kind      (m_rm_kind),
        .m_rm_code      (m_rm_code),
        .m_displacement (m_displacement)
    );

    mov_decode_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_code_byte    (s_code_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inst_valid   (m_inst_valid),
        .m_rm_first     (m_rm_first),
        .m_reg_code     (m_reg_code),
        .m_rm_kind      (m_rm_kind),
        .m_rm_code      (m_rm_code),
        .m_displacement (m_displacement),
        .pending        (pending),
        .error_count    (error_count),
        .mov_count      (mov_count),
        .skip_count     (skip_count)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d decodes outstanding",
                     cycle_count, pending);
            $display("[mov_instruction_byte_decoder] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_ready changes on the falling edge. Phases of random
    // length pick one of three behaviors: always ready, random stalls,
    // or a rotating stall mask. A requested hold-off overrides all.
    // ------------------------------------------------------------------
    int          hold_left  = 0;
    int          phase_left = 0;
    int          stall_mode = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    logic        hold_seen  = 1'b0;

    always @(negedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                phase_left <= $urandom_range(20, 200);
                stall_mask <= 16'($urandom) | 16'h0101;  // never all stall
            end else begin
                phase_left <= phase_left - 1;
                stall_mask <= {stall_mask[14:0], stall_mask[15]};
            end
            case (stall_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= stall_mask[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one code byte at the falling edge and hold it until taken.
    // Bursts of random length are separated by random idle gaps; a quarter
    // of the bursts start with no gap, which gives long gap-free stretches.
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 5) : 0;
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_code_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected beat has been seen.
    task automatic drain_outputs();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // Register/memory MOV with the displacement bytes its ModRM calls for
    task automatic send_regmem(input logic d, input logic w, input logic [7:0] modrm,
                               input logic [15:0] disp);
        put_byte({movdec_pkg::REGMEM_TAG, d, w});
        put_byte(modrm);
        if (modrm[7:6] == movdec_pkg::MOD_DISP8) begin
            put_byte(disp[7:0]);
        end else if (modrm[7:6] == movdec_pkg::MOD_DISP16 ||
                     (modrm[7:6] == movdec_pkg::MOD_NODISP &&
                      modrm[2:0] == movdec_pkg::DIRECT_RM)) begin
            put_byte(disp[7:0]);
            put_byte(disp[15:8]);
        end
    endtask

    // Accumulator MOV, address low byte first
    task automatic send_accum(input logic d, input logic w, input logic [15:0] addr);
        put_byte({movdec_pkg::ACCUM_TAG, d, w});
        put_byte(addr[7:0]);
        put_byte(addr[15:8]);
    endtask

    // Opcode byte that belongs to neither form
    task automatic send_junk_opcode();
        logic [7:0] b;
        b = 8'($urandom);
        while (b[7:2] == movdec_pkg::REGMEM_TAG || b[7:2] == movdec_pkg::ACCUM_TAG)
            b = 8'($urandom);
        put_byte(b);
    endtask

    task automatic send_random_mov();
        logic [7:0] modrm;
        int         pick;
        pick  = $urandom_range(0, 99);
        modrm = 8'($urandom);
        // Direct addressing is one ModRM value in 32; lift it a bit
        if ($urandom_range(0, 7) == 0)
            modrm = {movdec_pkg::MOD_NODISP, modrm[5:3], movdec_pkg::DIRECT_RM};
        if (pick < 50)
            send_regmem(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), modrm,
                        16'($urandom));
        else if (pick < 75)
            send_accum(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom));
        else if (pick < 88)
            send_junk_opcode();
        else if (pick < 94)
            put_byte(8'($urandom));     // raw noise, may land mid-instruction
        else
            // broken sequence: an opcode followed by whatever comes next
            put_byte($urandom_range(0, 1) ? {movdec_pkg::REGMEM_TAG, 2'($urandom)}
                                          : {movdec_pkg::ACCUM_TAG, 2'($urandom)});
    endtask

    int inst_count;

    initial begin
        // Every input known from time zero
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_code_byte = 8'h00;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // --------------------------------------------------------------
        // Directed
        // --------------------------------------------------------------
        put_byte(8'h00);                                // junk opcode, low end
        put_byte(8'hFF);                                // junk opcode, high end
        send_regmem(1'b0, 1'b1, 8'hD8, 16'h0000);       // reg to reg, r/m first
        send_regmem(1'b1, 1'b0, 8'h00, 16'h0000);       // based, no displacement
        send_regmem(1'b1, 1'b1, 8'h06, 16'h1234);       // mod 00 rm 110: direct
        send_regmem(1'b0, 1'b0, 8'h47, 16'h00FF);       // disp8 0xFF, no sign ext
        send_regmem(1'b1, 1'b1, 8'hBF, 16'hFFFF);       // disp16, all ones
        send_accum(1'b0, 1'b0, 16'h0000);               // load AL
        send_accum(1'b1, 1'b1, 16'hFFFF);               // store AX
        drain_outputs();

        // --------------------------------------------------------------
        // Random streams, with long receiver hold-offs early and later on (sender
        // keeps pushing, so the queue fills and s_ready drops) and a full
        // drain in the middle.
        // --------------------------------------------------------------
        inst_count = 0;
        while (bytes_sent < RANDOM_BYTES + 23) begin
            if (inst_count == 60 || inst_count == 250)
                hold_toggle = ~hold_toggle;
            if (inst_count == 150)
                drain_outputs();
            send_random_mov();
            inst_count++;
        end

        drain_outputs();
        repeat (8) @(negedge aclk);   // any stray beat would show up here

        $display("%0d code bytes sent: %0d MOV decodes and %0d skipped opcodes checked",
                 bytes_sent, mov_count, skip_count);
        $display("checker reported %0d mismatches in %0d cycles", error_count, cycle_count);
        if (error_count == 0)
            $display("[mov_instruction_byte_decoder] OK");
        else
            $display("[mov_instruction_byte_decoder] ERROR");
        $finish;
    end

endmodule
